// ===== rtl/core/rxmp32_pkg.sv =====
// Shared types, constants and mixing function for the ring xorshift PRNG.
`default_nettype none

package rxmp32_pkg;

	localparam int WORD_W         = 32;
	localparam int COST_W         = 7;
	localparam int RING_WORDS_DEF = 16;

	localparam logic [COST_W-1:0] COST_RESET = 7'd1;

	localparam int SHIFT_A = 3;
	localparam int SHIFT_B = 13;
	localparam int SHIFT_T = 7;

	localparam logic OP_PULL = 1'b0;
	localparam logic OP_PUSH = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDA,
		ST_MIX,
		ST_MUL,
		ST_SUM
	} state_t;

	// new front word from front word a and back word b
	function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W-1:0] t;
		t = a ^ (a >> SHIFT_A);
		return (b ^ (b << SHIFT_B)) ^ (t ^ (t << SHIFT_T));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ring_xorshift_mix_prng32.sv =====
// Top level of the ring xorshift PRNG: stream ports, round count register, core and ring.
`default_nettype none

// 32-bit generator over a ring of RING_WORDS words held in one synchronous RAM.
// tuser selects the word kind: 0 pulls a random word (one output word), 1 absorbs
// the tdata block over cost_rounds rounds (no output word); a push with cost_rounds
// 0 is taken and leaves the ring as it is. A pull waits until the output register
// is free before it gives its word. The single RAM read port reads the back word
// and then the front word; the words are mixed, with a pull writing the mixed word
// back, and then multiplied, and each push round mixes, multiplies and adds.
// The output word sits in a register, so the next word is taken while it waits.
// After reset the RAM is cleared, one word a cycle, before the first word is
// taken; cost_rounds writes are taken at any time.
module ring_xorshift_mix_prng32 #(
	parameter int RING_WORDS = rxmp32_pkg::RING_WORDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [rxmp32_pkg::COST_W-1:0] cfg_wr_data,   // cost_rounds
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [rxmp32_pkg::WORD_W-1:0] s_axis_tdata,  // block
	input  wire logic                          s_axis_tuser,  // operation
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic      [rxmp32_pkg::WORD_W-1:0] m_axis_tdata   // random_word
);

	localparam int AW = $clog2(RING_WORDS);

	logic [rxmp32_pkg::COST_W-1:0] cost_q;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr, rd_addr;
	logic [rxmp32_pkg::WORD_W-1:0] wr_data, rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= rxmp32_pkg::COST_RESET;
		end else if (cfg_wr_en) begin
			cost_q <= cfg_wr_data;
		end
	end

	rxmp32_ctrl #(
		.WORDS(RING_WORDS),
		.AW   (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cost_rounds(cost_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_block   (s_axis_tdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_word   (m_axis_tdata),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	rxmp32_ring #(
		.WORDS(RING_WORDS),
		.AW   (AW)
	) u_ring (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

`default_nettype wire

// ===== rtl/core/rxmp32_ring.sv =====
// Ring word memory: one write port, one read port, registered read data.
`default_nettype none

module rxmp32_ring #(
	parameter int WORDS = rxmp32_pkg::RING_WORDS_DEF,
	parameter int AW    = $clog2(WORDS)
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [rxmp32_pkg::WORD_W-1:0] wr_data,
	input  wire logic [AW-1:0]                 rd_addr,
	output logic      [rxmp32_pkg::WORD_W-1:0] rd_data
);

	logic [rxmp32_pkg::WORD_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/rxmp32_ctrl.sv =====
// Sequencer and datapath: reads, mixes and writes back ring words, holds the output word.
`default_nettype none

module rxmp32_ctrl #(
	parameter int WORDS = rxmp32_pkg::RING_WORDS_DEF,
	parameter int AW    = $clog2(WORDS)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [rxmp32_pkg::COST_W-1:0] cost_rounds,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          in_op,
	input  wire logic [rxmp32_pkg::WORD_W-1:0] in_block,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [rxmp32_pkg::WORD_W-1:0] out_word,
	output logic                               wr_en,
	output logic      [AW-1:0]                 wr_addr,
	output logic      [rxmp32_pkg::WORD_W-1:0] wr_data,
	output logic      [AW-1:0]                 rd_addr,
	input  wire logic [rxmp32_pkg::WORD_W-1:0] rd_data
);

	localparam logic [AW-1:0] LAST_IDX = AW'(WORDS - 1);

	rxmp32_pkg::state_t state_q, state_nx;

	logic [AW-1:0]                   front_q;
	logic [AW-1:0]                   clr_q;
	logic [rxmp32_pkg::COST_W-1:0]   rounds_q;
	logic                            op_q;
	logic                            first_q;
	logic                            out_valid_q;
	logic [rxmp32_pkg::WORD_W-1:0]   blk_q, b_q, a_q, c_q, s_q, prod_q, out_word_q;

	logic [AW-1:0]                   back_idx, next_idx;
	logic [rxmp32_pkg::WORD_W-1:0]   a_cur, c_new, s_new, mul, sum_new;
	logic                            accept, out_free;

	assign back_idx = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign next_idx = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign a_cur    = first_q ? rd_data : a_q;
	assign c_new    = rxmp32_pkg::mix_word(a_cur, b_q);
	assign s_new    = a_cur + b_q + 32'd1;
	assign mul      = s_q * c_q;
	assign sum_new  = b_q + blk_q + prod_q;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rxmp32_pkg::ST_CLEAR: begin
				if (clr_q == LAST_IDX) state_nx = rxmp32_pkg::ST_IDLE;
			end
			rxmp32_pkg::ST_IDLE: begin
				if (accept && (in_op == rxmp32_pkg::OP_PULL || cost_rounds != '0)) begin
					state_nx = rxmp32_pkg::ST_RDA;
				end
			end
			rxmp32_pkg::ST_RDA: state_nx = rxmp32_pkg::ST_MIX;
			rxmp32_pkg::ST_MIX: state_nx = rxmp32_pkg::ST_MUL;
			rxmp32_pkg::ST_MUL: begin
				if (op_q == rxmp32_pkg::OP_PUSH) state_nx = rxmp32_pkg::ST_SUM;
				else if (out_free) state_nx = rxmp32_pkg::ST_IDLE;
			end
			rxmp32_pkg::ST_SUM: begin
				if (rounds_q == 7'd1) state_nx = rxmp32_pkg::ST_IDLE;
				else state_nx = rxmp32_pkg::ST_MIX;
			end
			default: state_nx = rxmp32_pkg::ST_IDLE;
		endcase
	end

	// memory port and handshake
	always_comb begin
		in_ready = 1'b0;
		rd_addr  = front_q;
		wr_en    = 1'b0;
		wr_addr  = front_q;
		wr_data  = c_new;
		case (state_q)
			rxmp32_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			rxmp32_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = back_idx;
			end
			rxmp32_pkg::ST_MIX: begin
				wr_en = (op_q == rxmp32_pkg::OP_PULL);
			end
			rxmp32_pkg::ST_SUM: begin
				wr_en   = 1'b1;
				wr_data = sum_new;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rxmp32_pkg::ST_CLEAR;
			front_q     <= '0;
			clr_q       <= '0;
			rounds_q    <= '0;
			op_q        <= rxmp32_pkg::OP_PULL;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == rxmp32_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept) begin
				op_q     <= in_op;
				rounds_q <= cost_rounds;
			end
			if (state_q == rxmp32_pkg::ST_RDA) first_q <= 1'b1;
			if (state_q == rxmp32_pkg::ST_MIX) begin
				first_q <= 1'b0;
				if (op_q == rxmp32_pkg::OP_PULL) front_q <= next_idx;
			end
			if (state_q == rxmp32_pkg::ST_SUM) rounds_q <= rounds_q - 1'b1;
			if (state_q == rxmp32_pkg::ST_MUL && op_q == rxmp32_pkg::OP_PULL && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) blk_q <= in_block;
		if (state_q == rxmp32_pkg::ST_RDA) b_q <= rd_data;
		if (state_q == rxmp32_pkg::ST_MIX) begin
			c_q <= c_new;
			s_q <= s_new;
		end
		if (state_q == rxmp32_pkg::ST_MUL) begin
			prod_q <= mul;
			if (op_q == rxmp32_pkg::OP_PULL && out_free) out_word_q <= mul;
		end
		// next push round mixes the word just written, no reread
		if (state_q == rxmp32_pkg::ST_SUM) a_q <= sum_new;
	end

	a_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rxmp32_pkg::ST_IDLE || state_q == rxmp32_pkg::ST_RDA) |-> !wr_en)
		else $error("ring write outside a write state");

	a_front_move: assert property (@(posedge clk) disable iff (!arst_n)
		(front_q != $past(front_q)) |->
		($past(state_q) == rxmp32_pkg::ST_MIX && $past(op_q) == rxmp32_pkg::OP_PULL))
		else $error("front moved outside a pull");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == rxmp32_pkg::ST_MUL &&
		$past(op_q) == rxmp32_pkg::OP_PULL))
		else $error("output word not from a pull");

	a_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rxmp32_pkg::ST_SUM) |-> (rounds_q != '0))
		else $error("push round with no rounds left");

endmodule

`default_nettype wire
